/* hdl/dtip_pkg.sv */
// Shared types and constants for the decimal text to integer parser.
package dtip_pkg;

    localparam int CHAR_W = 21;
    localparam int KIND_W = 4;
    localparam int STAT_W = 3;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } in_item_t;

    typedef struct packed {
        logic [63:0]       value;
        logic [STAT_W-1:0] status;
    } out_item_t;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_INT   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_DEC   = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_EXP  = 3'd3;
    localparam logic [STAT_W-1:0] ST_TRAILING = 3'd4;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd5;
    localparam logic [STAT_W-1:0] ST_LITERAL  = 3'd6;

    localparam logic [KIND_W-1:0] KIND_BOOL = 4'd8;
    localparam logic [KIND_W-1:0] KIND_NULL = 4'd9;
    localparam logic [KIND_W-1:0] KIND_RSVD = 4'd10;

    // Parse summary handed from the scanner to the scaling unit.
    typedef struct packed {
        logic              lit_mode;
        logic              lit_true;
        logic [STAT_W-1:0] err;
        logic              neg;
        logic [63:0]       mant;
        logic [7:0]        dropped;
        logic [4:0]        kept;
        logic              sticky;
        logic [7:0]        exp_val;
        logic              exp_neg;
        logic [KIND_W-1:0] kind;
    } job_t;

    function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        unique case (w)
            2'd0: unique case (p)
                3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
                default: c = 8'h00;
            endcase
            2'd1: unique case (p)
                3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s";
                3'd4: c = "e"; default: c = 8'h00;
            endcase
            2'd2: unique case (p)
                3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l";
                default: c = 8'h00;
            endcase
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* hdl/dtip_scan.sv */
// Character scanner: accepts one character per cycle while s_ready is high and builds a parse summary.
module dtip_scan import dtip_pkg::*; #(
    parameter int MAX_VALUE_BITS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [KIND_W-1:0] kind,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              job_valid,
    input  logic              job_ready,
    output job_t              job
);

    typedef enum logic [3:0] {
        PH_START, PH_SIGN, PH_INT_ZERO, PH_INT, PH_DOT, PH_FRAC, PH_FRAC_FULL,
        PH_EXP_START, PH_EXP_SIGN, PH_EXP_DIGITS, PH_EXP_DONE,
        PH_LIT_TRUE, PH_LIT_FALSE, PH_LIT_NULL
    } phase_t;

    localparam logic [63:0] LIM = {64{1'b1}} >> (64 - MAX_VALUE_BITS);

    phase_t            ph_reg, ph_next;
    logic              neg_reg, neg_next;
    logic [63:0]       mant_reg, mant_next;
    logic [7:0]        drop_reg, drop_next;
    logic [4:0]        kept_reg, kept_next;
    logic              sticky_reg, sticky_next;
    logic [7:0]        ev_reg, ev_next;
    logic              en_reg, en_next;
    logic [2:0]        lp_reg, lp_next;
    logic [STAT_W-1:0] err_reg, err_next;

    logic [CHAR_W-1:0] ch;
    logic              is_dig, lit, take, dig_fits;
    logic [3:0]        dig;
    logic [1:0]        lw;
    logic [2:0]        llen;
    logic [STAT_W-1:0] ferr;
    job_t              j;

    assign s_ready = !job_valid || job_ready;
    assign take    = s_valid && s_ready;
    assign ch      = s_data.char_code;
    assign is_dig  = ch >= CHAR_W'(48) && ch <= CHAR_W'(57);
    assign dig     = ch[3:0];
    assign lit     = kind == KIND_BOOL || kind == KIND_NULL;
    // mant <= (LIM - dig)/10  <=>  mant*10 + dig <= LIM (checked in 68 bits)
    assign dig_fits = ({4'd0, mant_reg} * 68'd10 + 68'(dig)) <= {4'd0, LIM};

    always_comb begin
        ph_next = ph_reg; neg_next = neg_reg; mant_next = mant_reg;
        drop_next = drop_reg; kept_next = kept_reg; sticky_next = sticky_reg;
        ev_next = ev_reg; en_next = en_reg; lp_next = lp_reg; err_next = err_reg;
        lw = 2'd0;
        if (ph_reg == PH_LIT_FALSE) lw = 2'd1;
        else if (ph_reg == PH_LIT_NULL) lw = 2'd2;
        llen = (lw == 2'd1) ? 3'd5 : 3'd4;
        if (err_reg == ST_OK) begin
            if (lit) begin
                if (lp_reg == 3'd0) begin
                    if (kind == KIND_BOOL && ch == CHAR_W'("t")) ph_next = PH_LIT_TRUE;
                    else if (kind == KIND_BOOL && ch == CHAR_W'("f")) ph_next = PH_LIT_FALSE;
                    else if (kind == KIND_NULL && ch == CHAR_W'("n")) ph_next = PH_LIT_NULL;
                    else err_next = ST_LITERAL;
                end else if (ph_reg == PH_LIT_TRUE || ph_reg == PH_LIT_FALSE ||
                             ph_reg == PH_LIT_NULL) begin
                    if (lp_reg >= llen || ch != CHAR_W'(lit_char(lw, lp_reg)))
                        err_next = ST_LITERAL;
                end else begin
                    err_next = ST_LITERAL;
                end
                if (lp_reg < 3'd7) lp_next = lp_reg + 3'd1;
            end else begin
                unique case (ph_reg)
                    PH_START, PH_SIGN, PH_INT: begin
                        if (ph_reg == PH_START && ch == CHAR_W'("-")) begin
                            neg_next = 1'b1; ph_next = PH_SIGN;
                        end else if (ph_reg != PH_INT && ch == CHAR_W'("0")) begin
                            ph_next = PH_INT_ZERO;
                        end else if (is_dig) begin
                            ph_next = PH_INT;
                            if (drop_reg == 8'd0 && dig_fits)
                                mant_next = mant_reg * 64'd10 + 64'(dig);
                            else begin
                                if (drop_reg != 8'd255) drop_next = drop_reg + 8'd1;
                                if (dig != 4'd0) sticky_next = 1'b1;
                            end
                        end else if (ph_reg == PH_INT) begin
                            if (ch == CHAR_W'(".")) ph_next = PH_DOT;
                            else if (ch == CHAR_W'("e") || ch == CHAR_W'("E"))
                                ph_next = PH_EXP_START;
                            else err_next = ST_TRAILING;
                        end else begin
                            err_next = ST_NO_INT;
                        end
                    end
                    PH_INT_ZERO: begin
                        if (ch == CHAR_W'(".")) ph_next = PH_DOT;
                        else if (ch == CHAR_W'("e") || ch == CHAR_W'("E"))
                            ph_next = PH_EXP_START;
                        else err_next = ST_TRAILING;
                    end
                    PH_DOT, PH_FRAC, PH_FRAC_FULL: begin
                        if (is_dig) begin
                            if (ph_reg != PH_FRAC_FULL && drop_reg == 8'd0 &&
                                kept_reg < 5'd31 && dig_fits) begin
                                mant_next = mant_reg * 64'd10 + 64'(dig);
                                kept_next = kept_reg + 5'd1;
                                ph_next   = PH_FRAC;
                            end else begin
                                if (dig != 4'd0) sticky_next = 1'b1;
                                ph_next = PH_FRAC_FULL;
                            end
                        end else if (ph_reg == PH_DOT) begin
                            err_next = ST_NO_DEC;
                        end else if (ch == CHAR_W'("e") || ch == CHAR_W'("E")) begin
                            ph_next = PH_EXP_START;
                        end else begin
                            err_next = ST_TRAILING;
                        end
                    end
                    PH_EXP_START, PH_EXP_SIGN: begin
                        if (ph_reg == PH_EXP_START && ch == CHAR_W'("+")) begin
                            ph_next = PH_EXP_SIGN;
                        end else if (ph_reg == PH_EXP_START && ch == CHAR_W'("-")) begin
                            en_next = 1'b1; ph_next = PH_EXP_SIGN;
                        end else if (ch == CHAR_W'("0")) begin
                            ph_next = PH_EXP_DONE;
                        end else if (is_dig) begin
                            ev_next = 8'(dig); ph_next = PH_EXP_DIGITS;
                        end else begin
                            err_next = ST_BAD_EXP;
                        end
                    end
                    PH_EXP_DIGITS: begin
                        if (is_dig) ev_next = 8'(ev_reg * 8'd10 + 8'(dig));
                        else err_next = ST_TRAILING;
                    end
                    default: err_next = ST_TRAILING;
                endcase
            end
        end
        // end-of-string checks
        ferr = err_next;
        if (ferr == ST_OK) begin
            if (lit) begin
                if (!(ph_next == PH_LIT_TRUE || ph_next == PH_LIT_FALSE ||
                      ph_next == PH_LIT_NULL))
                    ferr = ST_LITERAL;
                else if (lp_next != ((ph_next == PH_LIT_FALSE) ? 3'd5 : 3'd4))
                    ferr = ST_LITERAL;
            end else if (ph_next == PH_START || ph_next == PH_SIGN) ferr = ST_NO_INT;
            else if (ph_next == PH_DOT) ferr = ST_NO_DEC;
            else if (ph_next == PH_EXP_START || ph_next == PH_EXP_SIGN) ferr = ST_BAD_EXP;
        end
        j.lit_mode = lit;
        j.lit_true = ph_next == PH_LIT_TRUE;
        j.err      = ferr;
        j.neg      = neg_next;
        j.mant     = mant_next;
        j.dropped  = drop_next;
        j.kept     = kept_next;
        j.sticky   = sticky_next;
        j.exp_val  = ev_next;
        j.exp_neg  = en_next;
        j.kind     = kind;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we || (take && s_data.last)) begin
            ph_reg <= PH_START; neg_reg <= 1'b0; mant_reg <= '0; drop_reg <= '0;
            kept_reg <= '0; sticky_reg <= 1'b0; ev_reg <= '0; en_reg <= 1'b0;
            lp_reg <= '0; err_reg <= ST_OK;
        end else if (take) begin
            ph_reg <= ph_next; neg_reg <= neg_next; mant_reg <= mant_next;
            drop_reg <= drop_next; kept_reg <= kept_next; sticky_reg <= sticky_next;
            ev_reg <= ev_next; en_reg <= en_next; lp_reg <= lp_next; err_reg <= err_next;
        end
    end

    // one-entry queue toward the scaling unit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid <= 1'b0;
        end else if (take && s_data.last) begin
            job_valid <= 1'b1;
        end else if (job_ready) begin
            job_valid <= 1'b0;
        end
        if (take && s_data.last) job <= j;
    end

endmodule

/* hdl/dtip_scale.sv */
// Scaling unit: applies the power of ten one step at a time and range checks.
module dtip_scale import dtip_pkg::*; #(
    parameter int MAX_VALUE_BITS = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      job_valid,
    output logic      job_ready,
    input  job_t      job,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_UP, S_DOWN, S_DIV1, S_DIV2, S_DIV3, S_CHECK
    } state_t;

    localparam logic [63:0] LIM = {64{1'b1}} >> (64 - MAX_VALUE_BITS);

    state_t          st_reg;
    job_t            jb_reg;
    logic [63:0]     mag_reg;
    logic [63:0]     quo_reg;
    logic            frac_reg, over_reg;
    logic [9:0]      cnt_reg;
    logic signed [10:0] e;
    logic [63:0]     t_a, t_b, rem, quo_fix, rem_fix;
    logic            out_load;
    logic [6:0]      bits;
    logic [63:0]     mask, pos_b, neg_b, bound, outv;
    logic [STAT_W-1:0] stat;

    assign e = (job.exp_neg ? -$signed({3'b0, job.exp_val}) : $signed({3'b0, job.exp_val}))
               + $signed({3'b0, job.dropped}) - $signed({6'b0, job.kept});

    // divide by ten with shifts and adds over states S_DOWN, S_DIV1, S_DIV2 and S_DIV3;
    // the estimate is at most one low, so one compare and subtract corrects it
    assign t_a = (mag_reg >> 1) + (mag_reg >> 2);
    assign t_b = quo_reg + (quo_reg >> 8);
    assign rem = mag_reg - ((quo_reg << 3) + (quo_reg << 1));

    always_comb begin
        if (rem > 64'd9) begin
            quo_fix = quo_reg + 64'd1;
            rem_fix = rem - 64'd10;
        end else begin
            quo_fix = quo_reg;
            rem_fix = rem;
        end
    end

    assign job_ready = st_reg == S_IDLE && (!m_valid || m_ready);

    assign out_load = (st_reg == S_IDLE && job_valid && job_ready &&
                       (job.lit_mode || job.err != ST_OK)) || st_reg == S_CHECK;

    always_comb begin
        bits  = 7'd8 << jb_reg.kind[1:0];
        mask  = (bits == 7'd64) ? {64{1'b1}} : ((64'd1 << bits) - 64'd1);
        if (jb_reg.kind < 4'd4) begin
            pos_b = mask >> 1; neg_b = pos_b + 64'd1;
        end else begin
            pos_b = mask; neg_b = '0;
        end
        if (pos_b > LIM) pos_b = LIM;
        if (neg_b > LIM) neg_b = LIM;
        bound = jb_reg.neg ? neg_b : pos_b;
        outv  = jb_reg.neg ? ((64'd0 - mag_reg) & mask) : mag_reg;
        if (jb_reg.kind >= KIND_RSVD || over_reg || mag_reg > bound ||
            (mag_reg == bound && frac_reg))
            stat = ST_RANGE;
        else
            stat = ST_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= S_IDLE;
            m_valid <= 1'b0;
        end else begin
            if (out_load) m_valid <= 1'b1;
            else if (m_valid && m_ready) m_valid <= 1'b0;
            unique case (st_reg)
                S_IDLE: if (job_valid && job_ready) begin
                    jb_reg   <= job;
                    mag_reg  <= job.mant;
                    if (job.lit_mode || job.err != ST_OK) begin
                        m_data.status <= job.err;
                        m_data.value  <= (job.lit_mode && job.err == ST_OK &&
                                          job.lit_true) ? 64'd1 : 64'd0;
                    end else if (job.dropped == 8'd255) begin
                        over_reg <= 1'b1;
                        frac_reg <= job.sticky;
                        st_reg   <= S_CHECK;
                    end else if (e >= 11'sd1) begin
                        over_reg <= job.sticky || job.dropped != 8'd0;
                        frac_reg <= 1'b0;
                        cnt_reg  <= 10'(e);
                        st_reg   <= (job.sticky || job.dropped != 8'd0) ? S_CHECK : S_UP;
                    end else begin
                        over_reg <= 1'b0;
                        frac_reg <= job.sticky;
                        cnt_reg  <= 10'(-e);
                        st_reg   <= S_DOWN;
                    end
                end
                S_UP: begin
                    // stop early once zero or overflow
                    if (cnt_reg == 10'd0 || mag_reg == 64'd0) st_reg <= S_CHECK;
                    else if (mag_reg > LIM / 64'd10) begin
                        over_reg <= 1'b1; st_reg <= S_CHECK;
                    end else begin
                        mag_reg <= mag_reg * 64'd10;
                        cnt_reg <= cnt_reg - 10'd1;
                    end
                end
                S_DOWN: begin
                    if (cnt_reg == 10'd0 || mag_reg == 64'd0) st_reg <= S_CHECK;
                    else begin
                        quo_reg <= t_a + (t_a >> 4);
                        st_reg  <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    quo_reg <= t_b + (t_b >> 16);
                    st_reg  <= S_DIV2;
                end
                S_DIV2: begin
                    quo_reg <= (quo_reg + (quo_reg >> 32)) >> 3;
                    st_reg  <= S_DIV3;
                end
                S_DIV3: begin
                    if (rem_fix != 64'd0) frac_reg <= 1'b1;
                    mag_reg <= quo_fix;
                    cnt_reg <= cnt_reg - 10'd1;
                    st_reg  <= S_DOWN;
                end
                S_CHECK: begin
                    m_data.status <= stat;
                    m_data.value  <= (stat == ST_OK) ? outv : 64'd0;
                    st_reg  <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* hdl/decimal_text_to_integer_parser.sv */
// Top level of the decimal text to integer parser.
// Input channel s_*: one character per transfer, s_data.last marks the final
// character of a string. Characters are taken one per cycle while s_ready is high.
// Result channel m_*: one transfer per string, carrying value and status.
// target_kind is to be written through cfg_we/cfg_data only while the block is
// idle, which the block itself does not enforce; a write drops any partial string.
// After the last character the parse summary is registered in the queue; a
// literal or an error then goes straight to the result register, otherwise the
// value is multiplied or divided by ten step by step and range checked. The loop
// stops once the value reaches zero or overflows, so at most 20 steps run.
// A one-entry queue between scanner and scaling unit lets the scanner take
// the next string's characters while a result is being scaled; a second
// finished string stalls the input until the queue drains.
// Reset: target_kind returns to int32 and the parse starts fresh.
// When m_ready is low the result holds in its register and the scaling
// unit, then the scanner, stop in turn.
module decimal_text_to_integer_parser import dtip_pkg::*; #(
    parameter int MAX_VALUE_BITS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [KIND_W-1:0] cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data
);

    logic [KIND_W-1:0] kind_reg;
    logic job_valid, job_ready;
    job_t job;

    always_ff @(posedge aclk) begin
        if (!aresetn) kind_reg <= 4'd2;
        else if (cfg_we) kind_reg <= cfg_data;
    end

    dtip_scan #(.MAX_VALUE_BITS(MAX_VALUE_BITS)) u_scan (
        .aclk, .aresetn, .cfg_we, .kind(kind_reg),
        .s_valid, .s_ready, .s_data,
        .job_valid, .job_ready, .job
    );

    dtip_scale #(.MAX_VALUE_BITS(MAX_VALUE_BITS)) u_scale (
        .aclk, .aresetn, .job_valid, .job_ready, .job,
        .m_valid, .m_ready, .m_data
    );

endmodule
